// File: hdl/telemetry_frame_builder_macros.svh
// assertion macros shared by the frame builder modules
// no dependencies; files that check their own logic include this header
`ifndef TELEMETRY_FRAME_BUILDER_MACROS_SVH
`define TELEMETRY_FRAME_BUILDER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, clocked and disabled during reset
`define TFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked and disabled during reset
`define TFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/tfb_pkg.sv
// shared types and constants of the telemetry frame builder
// no dependencies
package tfb_pkg;

    typedef logic [7:0] t_byte;

    localparam t_byte FrameHead  = 8'hAA;
    localparam t_byte AddrReset  = 8'hFF;
    localparam t_byte MaxPayload = 8'd250;

    // most bytes one request can produce: header, one payload byte, two checks
    localparam int unsigned BurstMax = 7;
    localparam int unsigned CntW     = $clog2(BurstMax + 1);

    // bytes produced by one request, sent lowest entry first
    typedef struct packed {
        logic [BurstMax-1:0][7:0] data;
        logic [CntW-1:0]          count;
        logic                     eof;
    } t_burst;

endpackage

// File: hdl/tfb_frame_engine.sv
// frame state and check arithmetic; builds the byte burst for one request
// depends on tfb_pkg and the assertion macro header
`include "telemetry_frame_builder_macros.svh"

module tfb_frame_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  tfb_pkg::t_byte i_src_addr,
    input  tfb_pkg::t_byte i_payload_byte,
    input  tfb_pkg::t_byte i_frame_id,
    input  tfb_pkg::t_byte i_payload_length,
    output tfb_pkg::t_burst o_burst
);

    localparam int unsigned PosW = $clog2(tfb_pkg::BurstMax);

    logic           r_in_frame;
    tfb_pkg::t_byte r_left;
    tfb_pkg::t_byte r_sum;
    tfb_pkg::t_byte r_acc;

    logic           n_in_frame;
    tfb_pkg::t_byte n_left;
    tfb_pkg::t_byte n_sum;
    tfb_pkg::t_byte n_acc;

    tfb_pkg::t_burst burst;

    // header bytes, check sums over the request, burst assembly
    always_comb begin
        tfb_pkg::t_byte [3:0] hdr;
        tfb_pkg::t_byte len_c;
        tfb_pkg::t_byte hs;
        tfb_pkg::t_byte ha;
        tfb_pkg::t_byte bs;
        tfb_pkg::t_byte ba;
        tfb_pkg::t_byte ds;
        tfb_pkg::t_byte da;
        tfb_pkg::t_byte fs;
        tfb_pkg::t_byte fa;
        tfb_pkg::t_byte left_base;
        tfb_pkg::t_byte left_next;
        logic           data_used;
        logic           closing;
        logic [PosW-1:0] pos;

        // clamp the length so the header carries what the frame really has
        len_c  = (i_payload_length > tfb_pkg::MaxPayload) ? tfb_pkg::MaxPayload
                                                           : i_payload_length;
        hdr[0] = tfb_pkg::FrameHead;
        hdr[1] = i_src_addr;
        hdr[2] = i_frame_id;
        hdr[3] = len_c;

        // running sum and accumulated sum over the four header bytes
        hs = '0;
        ha = '0;
        for (int i = 0; i < 4; i++) begin
            hs = hs + hdr[i];
            ha = ha + hs;
        end

        bs = r_in_frame ? r_sum : hs;
        ba = r_in_frame ? r_acc : ha;

        data_used = r_in_frame || (len_c != '0);
        ds        = bs + i_payload_byte;
        da        = ba + ds;
        left_base = r_in_frame ? r_left : len_c;
        left_next = left_base - 8'd1;
        closing   = !data_used || (left_next == '0);
        fs        = data_used ? ds : bs;
        fa        = data_used ? da : ba;

        // lay the bytes out in send order
        burst = '0;
        pos   = '0;
        if (!r_in_frame) begin
            for (int i = 0; i < 4; i++) begin
                burst.data[i] = hdr[i];
            end
            pos = PosW'(4);
        end
        if (data_used) begin
            burst.data[pos] = i_payload_byte;
            pos = pos + PosW'(1);
        end
        if (closing) begin
            burst.data[pos] = fs;
            burst.data[pos + PosW'(1)] = fa;
            pos = pos + PosW'(2);
        end
        burst.count = tfb_pkg::CntW'(pos);
        burst.eof   = closing;

        // frame state after this request
        if (closing) begin
            n_in_frame = 1'b0;
            n_left     = '0;
            n_sum      = '0;
            n_acc      = '0;
        end else begin
            n_in_frame = 1'b1;
            n_left     = left_next;
            n_sum      = ds;
            n_acc      = da;
        end
    end

    assign o_burst = burst;

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_left     <= '0;
            r_sum      <= '0;
            r_acc      <= '0;
        end else if (i_accept) begin
            r_in_frame <= n_in_frame;
            r_left     <= n_left;
            r_sum      <= n_sum;
            r_acc      <= n_acc;
        end
    end

    // open frame always has payload still to come
    `TFB_ASSERT_IMP(a_left_in_frame, i_clk, i_rst_n, r_in_frame, r_left != '0, "open frame with no bytes left")
    // between frames the counters sit at zero
    `TFB_ASSERT_IMP(a_idle_clear, i_clk, i_rst_n, !r_in_frame, (r_left == '0) && (r_sum == '0) && (r_acc == '0), "frame state not cleared between frames")

endmodule

// File: hdl/tfb_byte_serializer.sv
// holds one burst and sends it out one byte per cycle while the output is not stalled
// depends on tfb_pkg and the assertion macro header
`include "telemetry_frame_builder_macros.svh"

module tfb_byte_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  tfb_pkg::t_burst i_burst,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output tfb_pkg::t_byte  o_out_byte,
    output logic            o_end_of_frame,
    output logic            o_busy
);

    logic [tfb_pkg::BurstMax-1:0][7:0] r_data;
    logic [tfb_pkg::CntW-1:0]          r_cnt;
    logic                              r_eof;

    logic take;

    assign o_out_valid    = (r_cnt != '0);
    assign take           = o_out_valid && !i_out_stall;
    assign o_out_byte     = r_data[0];
    assign o_end_of_frame = r_eof && (r_cnt == tfb_pkg::CntW'(1));

    // a new burst fits once the current one is gone by the next edge
    assign o_busy = (r_cnt > tfb_pkg::CntW'(1)) ||
                    ((r_cnt == tfb_pkg::CntW'(1)) && i_out_stall);

    // burst payload: load or shift down one byte per byte sent
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_burst.data;
        end else if (take) begin
            r_data <= {8'h00, r_data[tfb_pkg::BurstMax-1:1]};
        end
    end

    // byte count and frame-end flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_eof <= 1'b0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
            r_eof <= i_burst.eof;
        end else if (take) begin
            r_cnt <= r_cnt - tfb_pkg::CntW'(1);
        end
    end

    // a load never overwrites bytes still to be sent
    `TFB_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_load, (r_cnt == '0) || ((r_cnt == tfb_pkg::CntW'(1)) && take), "burst loaded over unsent bytes")
    // each byte sent without a load drops the count by one
    `TFB_ASSERT_NXT(a_count_step, i_clk, i_rst_n, take && !i_load, r_cnt == $past(r_cnt) - tfb_pkg::CntW'(1), "byte count did not step")

endmodule

// File: hdl/telemetry_frame_builder.sv
// top level of the telemetry frame builder: handshakes and address register
// depends on tfb_pkg, tfb_frame_engine and tfb_byte_serializer

// Each accepted request yields a burst of output bytes, one byte per cycle on
// the output channel while it is not stalled: the first request of a frame
// gives five bytes (header and the first payload byte), six for a zero-length
// frame, seven for a one-byte frame; middle requests give one byte and the
// closing request three (payload byte and both checks). With the output never
// stalled, a request is taken in every cycle in mid frame, and the next request
// is taken in the cycle the last byte of the current burst leaves. The single
// burst register of the serializer stalls a new request until the current burst
// is through. The source address register resets to 0xFF and is read when a
// header is built. Payload lengths above 250 are clamped to 250.
module telemetry_frame_builder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_payload_byte,
    input  logic [7:0] i_frame_id,
    input  logic [7:0] i_payload_length,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_end_of_frame
);

    tfb_pkg::t_byte  r_src_addr;
    tfb_pkg::t_burst burst;
    logic            busy;
    logic            accept;

    // source address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_addr <= tfb_pkg::AddrReset;
        end else if (i_cfg_wr_en) begin
            r_src_addr <= i_cfg_wr_data;
        end
    end

    // input handshake
    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    tfb_frame_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_src_addr       (r_src_addr),
        .i_payload_byte   (i_payload_byte),
        .i_frame_id       (i_frame_id),
        .i_payload_length (i_payload_length),
        .o_burst          (burst)
    );

    tfb_byte_serializer u_serializer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept),
        .i_burst        (burst),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_end_of_frame (o_end_of_frame),
        .o_busy         (busy)
    );

endmodule
